/* design/ubd_pkg.sv */
// Package for the UART baud divisor block: clock constants and prescaler tables.
`default_nettype none
package ubd_pkg;

  // Half of the 8 MHz oscillator; every system clock is a multiple of it
  localparam int unsigned OSC_HALF_HZ = 4_000_000;

  // Field widths
  localparam int unsigned CW_W   = 32;
  localparam int unsigned BAUD_W = 24;
  localparam int unsigned CLK_W  = 28;
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned MUL_W  = 6;   // clock multiple of OSC_HALF_HZ, 0..34
  localparam int unsigned SH_W   = 4;   // total prescaler shift, 0..13

  // Divider steps, one quotient bit each
  localparam int unsigned DIV_STEPS = DIV_W;

  // Clock configuration word bit positions
  localparam int unsigned SRC_LSB      = 2;
  localparam int unsigned AHB_LSB      = 4;
  localparam int unsigned SLOW_BUS_LSB = 8;
  localparam int unsigned FAST_BUS_LSB = 11;
  localparam int unsigned PLL_SRC_POS  = 16;
  localparam int unsigned PLL_PRE_POS  = 17;
  localparam int unsigned PLL_MUL_LSB  = 18;

  // System clock source codes
  typedef enum logic [1:0] {
    SRC_OSC0 = 2'd0,
    SRC_OSC1 = 2'd1,
    SRC_PLL  = 2'd2,
    SRC_NONE = 2'd3
  } clk_src_t;

  // AHB prescaler code to right shift
  function automatic logic [SH_W-1:0] ahb_shift(input logic [3:0] code);
    logic [SH_W-1:0] sh;
    case (code)
      4'd8:    sh = 4'd1;
      4'd9:    sh = 4'd2;
      4'd10:   sh = 4'd3;
      4'd11:   sh = 4'd4;
      4'd12:   sh = 4'd6;
      4'd13:   sh = 4'd7;
      4'd14:   sh = 4'd8;
      4'd15:   sh = 4'd9;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

  // APB prescaler code to right shift
  function automatic logic [SH_W-1:0] apb_shift(input logic [2:0] code);
    logic [SH_W-1:0] sh;
    case (code)
      3'd4:    sh = 4'd1;
      3'd5:    sh = 4'd2;
      3'd6:    sh = 4'd3;
      3'd7:    sh = 4'd4;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage
`default_nettype wire

/* design/uart_baud_divisor_from_clock_tree.sv */
// Top level: pipelined peripheral clock derivation and rounded baud divisor.
//
//  channel  | ports                                         | transfer
//  ---------+-----------------------------------------------+---------------------------
//  input    | start, busy, in_clock_config, in_baud_rate,   | start high, busy low
//           | in_on_fast_bus                                |
//  result   | out_valid, out_divisor,                       | out_valid high, one cycle
//           | out_peripheral_clock_hz, out_divisor_saturated,|
//           | out_baud_invalid                              |
//
// One item enters per cycle; busy is always low. Each result passes through three
// front stages (decode, clock multiply and shift, round and overflow check),
// then 16 restoring-divider stages, one quotient bit each, and an output register.
// Reset clears only the valid bits. The receiver cannot hold results off, so
// nothing in the pipeline ever waits.
`default_nettype none
module uart_baud_divisor_from_clock_tree
  import ubd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CW_W-1:0]     in_clock_config,
  input  wire logic [BAUD_W-1:0]   in_baud_rate,
  input  wire logic                in_on_fast_bus,
  output logic                     out_valid,
  output logic [DIV_W-1:0]         out_divisor,
  output logic [CLK_W-1:0]         out_peripheral_clock_hz,
  output logic                     out_divisor_saturated,
  output logic                     out_baud_invalid
);

  localparam int unsigned LATENCY = DIV_STEPS + 4;
  localparam int unsigned WIDE_W  = BAUD_W + DIV_W;

  logic in_xfer;
  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  // ---------------- stage 1: decode clock source and prescalers ----------------
  logic              v1_r;
  logic [MUL_W-1:0]  m1_r, m1_nxt;
  logic [SH_W-1:0]   sh1_r, sh1_nxt;
  logic [BAUD_W-1:0] baud1_r;

  clk_src_t         src;
  logic [4:0]       pll_fac;
  logic             pll_half;
  logic [2:0]       apb_code;

  always_comb begin
    src      = clk_src_t'(in_clock_config[SRC_LSB +: 2]);
    pll_fac  = {1'b0, in_clock_config[PLL_MUL_LSB +: 4]} + 5'd2;
    pll_half = ~in_clock_config[PLL_SRC_POS] | in_clock_config[PLL_PRE_POS];
    case (src)
      SRC_OSC0, SRC_OSC1: m1_nxt = MUL_W'(2);
      SRC_PLL:            m1_nxt = pll_half ? MUL_W'(pll_fac) : {pll_fac, 1'b0};
      default:            m1_nxt = '0;
    endcase
    apb_code = in_on_fast_bus ? in_clock_config[FAST_BUS_LSB +: 3]
                              : in_clock_config[SLOW_BUS_LSB +: 3];
    sh1_nxt  = ahb_shift(in_clock_config[AHB_LSB +: 4]) + apb_shift(apb_code);
  end

  // ---------------- stage 2: scale and apply prescalers ----------------
  logic              v2_r;
  logic [CLK_W-1:0]  clk2_r, clk2_nxt;
  logic [BAUD_W-1:0] baud2_r;

  always_comb begin
    clk2_nxt = (CLK_W'(m1_r) * CLK_W'(OSC_HALF_HZ)) >> sh1_r;
  end

  // ---------------- stage 3: rounding offset and overflow check ----------------
  logic [CLK_W-1:0]  dvd3_nxt;
  logic              sat3_nxt;

  always_comb begin
    dvd3_nxt = clk2_r + CLK_W'(baud2_r >> 1);
    // quotient exceeds 16 bits when dividend >= baud * 2^16
    sat3_nxt = {{(BAUD_W-CLK_W+DIV_W){1'b0}}, dvd3_nxt[CLK_W-1:DIV_W]} >= baud2_r;
  end

  // Divider pipeline registers; index 0 is the stage 3 output
  logic              dv_r    [0:DIV_STEPS];
  logic [CLK_W-1:0]  rem_r   [0:DIV_STEPS];
  logic [DIV_W-1:0]  quo_r   [0:DIV_STEPS];
  logic [BAUD_W-1:0] dbaud_r [0:DIV_STEPS];
  logic [CLK_W-1:0]  dclk_r  [0:DIV_STEPS];
  logic              dsat_r  [0:DIV_STEPS];

  // Front stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else begin
      v1_r     <= in_xfer;
      v2_r     <= v1_r;
      dv_r[0]  <= v2_r;
    end
  end

  // Front stage payload
  always_ff @(posedge clk) begin
    m1_r       <= m1_nxt;
    sh1_r      <= sh1_nxt;
    baud1_r    <= in_baud_rate;
    clk2_r     <= clk2_nxt;
    baud2_r    <= baud1_r;
    rem_r[0]   <= dvd3_nxt;
    quo_r[0]   <= '0;
    dbaud_r[0] <= baud2_r;
    dclk_r[0]  <= clk2_r;
    dsat_r[0]  <= sat3_nxt;
  end

  // ---------------- restoring divider, one quotient bit per stage ----------------
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [WIDE_W-1:0] bsh;
    logic [WIDE_W:0]   diff;
    logic              ge;
    logic [CLK_W-1:0]  rem_nxt;

    always_comb begin
      bsh     = {{DIV_W{1'b0}}, dbaud_r[k-1]} << (DIV_STEPS - k);
      diff    = {{(WIDE_W-CLK_W+1){1'b0}}, rem_r[k-1]} - {1'b0, bsh};
      ge      = ~diff[WIDE_W];
      rem_nxt = ge ? diff[CLK_W-1:0] : rem_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k] <= 1'b0;
      end else begin
        dv_r[k] <= dv_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]   <= rem_nxt;
      quo_r[k]   <= {quo_r[k-1][DIV_W-2:0], ge};
      dbaud_r[k] <= dbaud_r[k-1];
      dclk_r[k]  <= dclk_r[k-1];
      dsat_r[k]  <= dsat_r[k-1];
    end
  end

  // ---------------- output register ----------------
  logic              out_valid_r;
  logic [DIV_W-1:0]  out_div_r, out_div_nxt;
  logic [CLK_W-1:0]  out_clk_r;
  logic              out_sat_r, out_sat_nxt;
  logic              out_bad_r, out_bad_nxt;

  always_comb begin
    out_bad_nxt = (dbaud_r[DIV_STEPS] == '0);
    out_sat_nxt = dsat_r[DIV_STEPS] & ~out_bad_nxt;
    if (out_bad_nxt) begin
      out_div_nxt = '0;
    end else if (out_sat_nxt) begin
      out_div_nxt = '1;
    end else begin
      out_div_nxt = quo_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    out_div_r <= out_div_nxt;
    out_clk_r <= dclk_r[DIV_STEPS];
    out_sat_r <= out_sat_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid               = out_valid_r;
  assign out_divisor             = out_div_r;
  assign out_peripheral_clock_hz = out_clk_r;
  assign out_divisor_saturated   = out_sat_r;
  assign out_baud_invalid        = out_bad_r;

  // ---------------- assertions ----------------
  // every accepted item comes out after the fixed pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##LATENCY out_valid)
    else $error("result missing after pipeline latency");

  // nothing comes out that was not started
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, LATENCY))
    else $error("result without a matching start");

  // zero baud forces a zero divisor and no saturation flag
  a_bad_baud: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_baud_invalid) |-> (out_divisor == '0 && !out_divisor_saturated))
    else $error("zero baud result inconsistent");

  // saturation clamps the divisor to all ones
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divisor_saturated) |-> (out_divisor == '1))
    else $error("saturated divisor not clamped");

endmodule
`default_nettype wire
